[src/rbd_pkg.sv]
// Package for the RGBA 2x2 box downsampler: payload structs, register
// indexes and field widths. Depends on nothing; every file in src uses it.
package rbd_pkg;

  localparam int CHAN_W = 8;
  localparam int PAIR_W = CHAN_W + 1;
  localparam int QUAD_W = CHAN_W + 2;
  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W = CFG_W;
  localparam int HALF_ROW_W = ROW_W - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] SRC_WIDTH_RST = 13'd256;
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd256;

  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              out_last;
  } pix_out_t;

  // Four 9-bit sums of a horizontal pixel pair, one per channel.
  typedef struct packed {
    logic [PAIR_W-1:0] red;
    logic [PAIR_W-1:0] green;
    logic [PAIR_W-1:0] blue;
    logic [PAIR_W-1:0] alpha;
  } pair_sum_t;

  localparam int PAIR_SUM_W = $bits(pair_sum_t);

  function automatic pair_sum_t pair_add(pix_in_t a, pix_in_t b);
    pair_sum_t s;
    s.red   = PAIR_W'(a.in_red)   + PAIR_W'(b.in_red);
    s.green = PAIR_W'(a.in_green) + PAIR_W'(b.in_green);
    s.blue  = PAIR_W'(a.in_blue)  + PAIR_W'(b.in_blue);
    s.alpha = PAIR_W'(a.in_alpha) + PAIR_W'(b.in_alpha);
    return s;
  endfunction

  // Sum of two pair sums over four, truncated.
  function automatic logic [CHAN_W-1:0] quad_avg(logic [PAIR_W-1:0] a,
                                                 logic [PAIR_W-1:0] b);
    logic [QUAD_W-1:0] s;
    s = QUAD_W'(a) + QUAD_W'(b);
    return s[QUAD_W-1:2];
  endfunction

endpackage

[src/rbd_line_buf.sv]
// Line buffer of pair sums for the RGBA 2x2 box downsampler.
// One write port, one read port with registered read data; uses rbd_pkg.
module rbd_line_buf
  import rbd_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW = 11
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [PAIR_SUM_W-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [PAIR_SUM_W-1:0] rd_data
);

  logic [PAIR_SUM_W-1:0] mem_r [DEPTH];
  logic [PAIR_SUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/rgba_box_downsample_2x2_core.sv]
// Top level of the RGBA 2x2 box downsampler (one mipmap step).
// Depends on rbd_pkg and rbd_line_buf.
//
// Source pixels enter in raster order, one item per clock when the result
// side keeps up, and each finished 2x2 block leaves as one destination item
// through stage 1 and the output register. The per-channel
// average is the block sum shifted right by two. An odd last column or row
// of the source is taken in and dropped, and if either destination
// dimension is zero no item is ever produced. Pair sums of even source rows
// wait in a line buffer of MAX_WIDTH/2 entries of 36 bits, which is a
// single-port-write, single-port-read memory with registered read data; it
// needs no clearing after reset because every entry is written on an even
// row before the odd row below reads it. The throughput of one item per
// cycle is set by that memory: the read is issued at the accepting edge and
// its data meets the registered pair sum of the current pixel in the next
// cycle, feeding the output register. A stage register and the output
// register together let a new item be accepted while a result still waits
// for the consumer. The width and height registers should be written only
// while the block is idle; after the last pixel of a level the position
// counters return to zero, so the next pixel starts a new level. Widths
// above MAX_WIDTH are treated as MAX_WIDTH.
module rgba_box_downsample_2x2_core
  import rbd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pix_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pix_out_t             out_data
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  // Configuration registers.
  logic [CFG_W-1:0] src_width_r;
  logic [CFG_W-1:0] src_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data;
        CFG_SRC_HEIGHT: src_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes: the width is clipped to what the line buffer can hold.
  logic [WW-1:0]         eff_width;
  logic [WW-2:0]         dst_width;
  logic [HALF_ROW_W-1:0] dst_height;

  assign eff_width  = (32'(src_width_r) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
                                                          : WW'(src_width_r);
  assign dst_width  = eff_width[WW-1:1];
  assign dst_height = src_height_r[ROW_W-1:1];

  // Position of the next source pixel.
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  pix_in_t          hold_r;

  // Pipeline: stage 1 carries the pair sum while the line buffer reads,
  // then the output register presents the averaged item.
  logic      s1_valid_r, s1_valid_nxt;
  pair_sum_t s1_pair_r;
  logic      s1_last_r;
  logic      out_valid_r;
  pix_out_t  out_data_r;

  logic      in_acc;
  logic      out_free;
  logic      col_end, row_end;
  logic      in_block;
  logic      odd_col, odd_row;
  logic      mem_we, mem_re;
  logic      blk_last;
  logic [AW-1:0] line_idx;
  pair_sum_t cur_pair;
  pair_sum_t above_pair;
  logic [PAIR_SUM_W-1:0] above_bits;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign col_end = ((WW+1)'(col_r) + (WW+1)'(1)) >= (WW+1)'(eff_width);
  assign row_end = ((ROW_W+1)'(row_r) + (ROW_W+1)'(1)) >= (ROW_W+1)'(src_height_r);

  assign in_block = (dst_width != '0) && (dst_height != '0)
                 && (WW'(col_r) < {dst_width, 1'b0})
                 && (row_r < {dst_height, 1'b0});

  assign odd_col  = col_r[0];
  assign odd_row  = row_r[0];
  assign line_idx = AW'(col_r >> 1);
  assign cur_pair = pair_add(hold_r, in_data);

  assign mem_we = in_acc && in_block && odd_col && !odd_row;
  assign mem_re = in_acc && in_block && odd_col && odd_row;

  assign blk_last = ((WW-1)'(col_r >> 1) == dst_width - (WW-1)'(1))
                 && (HALF_ROW_W'(row_r >> 1) == dst_height - HALF_ROW_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      hold_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_acc && in_block && !odd_col) begin
        hold_r <= in_data;
      end
    end
  end

  rbd_line_buf #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (line_idx),
    .wr_data (cur_pair),
    .rd_en   (mem_re),
    .rd_addr (line_idx),
    .rd_data (above_bits)
  );

  assign above_pair = pair_sum_t'(above_bits);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = mem_re;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      s1_pair_r <= cur_pair;
      s1_last_r <= blk_last;
    end
    if (out_free && s1_valid_r) begin
      out_data_r.out_red   <= quad_avg(above_pair.red, s1_pair_r.red);
      out_data_r.out_green <= quad_avg(above_pair.green, s1_pair_r.green);
      out_data_r.out_blue  <= quad_avg(above_pair.blue, s1_pair_r.blue);
      out_data_r.out_alpha <= quad_avg(above_pair.alpha, s1_pair_r.alpha);
      out_data_r.out_last  <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The line buffer is never written and read for the same item.
  a_no_rw_same_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("line buffer written and read in one cycle");

  // An item that completes a block is waiting in stage 1 on the next cycle.
  a_block_reaches_s1: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> s1_valid_r)
    else $error("completed block lost before stage 1");

  // A full pipeline with a stalled consumer takes no new item.
  a_full_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("item accepted while pipeline full");

  // The last pixel of a level sends both counters back to the origin.
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && col_end && row_end) |=> (col_r == '0 && row_r == '0))
    else $error("counters not cleared at end of level");

endmodule
